// ===== src/segx_pkg.sv =====
package segx_pkg;

	localparam int MAX_POINTS = 16;
	localparam int COORD_BITS = 16;
	localparam int READY_MIN  = 3;
	localparam int SEG_DEPTH  = MAX_POINTS * (MAX_POINTS - 1) / 2;

	localparam int IN_W      = 16;
	localparam int CNT_OUT_W = 5;

	localparam int PT_W  = 2 * COORD_BITS;
	localparam int SEG_W = 4 * COORD_BITS;
	localparam int PCW   = $clog2(MAX_POINTS + 1);
	localparam int PIW   = $clog2(MAX_POINTS);
	localparam int SCW   = $clog2(SEG_DEPTH + 1);
	localparam int SIW   = $clog2(SEG_DEPTH);

	localparam int DIFF_W = COORD_BITS + 1;
	localparam int PROD_W = 2 * DIFF_W;
	localparam int ORI_W  = PROD_W + 1;

	localparam logic FUNC_ADD    = 1'b0;
	localparam logic FUNC_QRY    = 1'b1;
	localparam logic STATUS_DONE = 1'b0;
	localparam logic STATUS_FULL = 1'b1;

	typedef logic signed [COORD_BITS-1:0] coord_t;

	typedef struct packed {
		coord_t y;
		coord_t x;
	} point_t;

	typedef struct packed {
		point_t b;
		point_t a;
	} seg_t;

	typedef struct packed {
		logic pos;
		logic neg;
	} sign_t;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_ADD,
		ST_QRY,
		ST_DRAIN,
		ST_RESP
	} state_t;

endpackage

// ===== src/segment_crossing_against_stored_mesh.sv =====
// An add writes one segment per cycle, one for each held point; a query reads one stored
// segment per cycle through a 4-stage compare pipe. A full add, the first add and a query
// with no stored segments go straight to the result register.
// One item at a time: the next transfer is taken the cycle after the result register loads;
// one waiting result does not block the input side.
// Reset clears counts and control; point and segment memories are not cleared.
module segment_crossing_against_stored_mesh (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             req_valid,
	output logic                             req_ready,
	input  logic                             func,
	input  logic signed [segx_pkg::IN_W-1:0] first_x,
	input  logic signed [segx_pkg::IN_W-1:0] first_y,
	input  logic signed [segx_pkg::IN_W-1:0] second_x,
	input  logic signed [segx_pkg::IN_W-1:0] second_y,
	output logic                             rsp_valid,
	input  logic                             rsp_ready,
	output logic                             status,
	output logic                             crosses,
	output logic [segx_pkg::CNT_OUT_W-1:0]   point_count,
	output logic                             ready_res
);

	segx_pkg::state_t state_q, state_d;

	logic [segx_pkg::PCW-1:0] points_q;
	logic [segx_pkg::SCW-1:0] seg_held_q;
	logic [segx_pkg::SCW-1:0] idx_q;
	logic [segx_pkg::SCW-1:0] lim_q;
	logic                     func_q;
	logic                     status_q;
	logic                     crosses_q;
	logic                     rsp_valid_q;
	logic                     rd_s1, v_s2, v_s3, v_s4;
	logic                     skip_s2, skip_s3, skip_s4;

	segx_pkg::point_t p_q, q_q, p_in;
	segx_pkg::seg_t   seg_rd;

	logic [segx_pkg::PT_W-1:0]  pt_rdata;
	logic [segx_pkg::SEG_W-1:0] seg_rdata;

	logic accept, full, last, rd_en, load, skip_s1, hit;

	segx_pkg::sign_t o1, o2, o3, o4;

	assign accept = req_valid && req_ready;
	assign full   = (points_q == segx_pkg::PCW'(segx_pkg::MAX_POINTS));
	assign last   = ((idx_q + segx_pkg::SCW'(1)) == lim_q);
	assign load   = (state_q == segx_pkg::ST_RESP) && (!rsp_valid_q || rsp_ready);

	assign p_in.x = $signed(first_x[segx_pkg::COORD_BITS-1:0]);
	assign p_in.y = $signed(first_y[segx_pkg::COORD_BITS-1:0]);

	always_comb begin
		state_d   = state_q;
		rd_en     = 1'b0;
		req_ready = 1'b0;
		unique case (state_q)
			segx_pkg::ST_IDLE: begin
				req_ready = 1'b1;
				if (req_valid) begin
					if (func == segx_pkg::FUNC_QRY) begin
						state_d = (seg_held_q == '0) ? segx_pkg::ST_RESP : segx_pkg::ST_QRY;
					end else begin
						state_d = (full || points_q == '0) ? segx_pkg::ST_RESP
							: segx_pkg::ST_ADD;
					end
				end
			end
			segx_pkg::ST_ADD, segx_pkg::ST_QRY: begin
				rd_en = 1'b1;
				if (last) begin
					state_d = segx_pkg::ST_DRAIN;
				end
			end
			segx_pkg::ST_DRAIN: begin
				if (!rd_s1 && !v_s2 && !v_s3 && !v_s4) begin
					state_d = segx_pkg::ST_RESP;
				end
			end
			segx_pkg::ST_RESP: begin
				if (load) begin
					state_d = segx_pkg::ST_IDLE;
				end
			end
			default: state_d = segx_pkg::ST_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= segx_pkg::ST_IDLE;
			points_q    <= '0;
			seg_held_q  <= '0;
			idx_q       <= '0;
			rd_s1       <= 1'b0;
			v_s2        <= 1'b0;
			v_s3        <= 1'b0;
			v_s4        <= 1'b0;
			rsp_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (accept) begin
				idx_q <= '0;
				if (func == segx_pkg::FUNC_ADD && !full) begin
					points_q <= points_q + segx_pkg::PCW'(1);
				end
			end else if (rd_en) begin
				idx_q <= idx_q + segx_pkg::SCW'(1);
			end
			rd_s1 <= rd_en;
			v_s2  <= rd_s1 && (func_q == segx_pkg::FUNC_QRY);
			v_s3  <= v_s2;
			v_s4  <= v_s3;
			if (rd_s1 && func_q == segx_pkg::FUNC_ADD) begin
				seg_held_q <= seg_held_q + segx_pkg::SCW'(1);
			end
			if (load) begin
				rsp_valid_q <= 1'b1;
			end else if (rsp_ready) begin
				rsp_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			func_q    <= func;
			p_q       <= p_in;
			q_q.x     <= $signed(second_x[segx_pkg::COORD_BITS-1:0]);
			q_q.y     <= $signed(second_y[segx_pkg::COORD_BITS-1:0]);
			lim_q     <= (func == segx_pkg::FUNC_QRY) ? seg_held_q : segx_pkg::SCW'(points_q);
			status_q  <= (func == segx_pkg::FUNC_ADD && full) ? segx_pkg::STATUS_FULL
				: segx_pkg::STATUS_DONE;
			crosses_q <= 1'b0;
		end else if (hit) begin
			crosses_q <= 1'b1;
		end
		skip_s2 <= skip_s1;
		skip_s3 <= skip_s2;
		skip_s4 <= skip_s3;
		if (load) begin
			status      <= status_q;
			crosses     <= crosses_q;
			point_count <= segx_pkg::CNT_OUT_W'(points_q);
			ready_res   <= (points_q >= segx_pkg::PCW'(segx_pkg::READY_MIN));
		end
	end

	assign rsp_valid = rsp_valid_q;

	segx_ram #(
		.WIDTH(segx_pkg::PT_W),
		.DEPTH(segx_pkg::MAX_POINTS)
	) u_pt_ram (
		.clk  (clk),
		.we   (accept && func == segx_pkg::FUNC_ADD && !full),
		.waddr(points_q[segx_pkg::PIW-1:0]),
		.wdata(p_in),
		.re   (rd_en && func_q == segx_pkg::FUNC_ADD),
		.raddr(idx_q[segx_pkg::PIW-1:0]),
		.rdata(pt_rdata)
	);

	segx_ram #(
		.WIDTH(segx_pkg::SEG_W),
		.DEPTH(segx_pkg::SEG_DEPTH)
	) u_seg_ram (
		.clk  (clk),
		.we   (rd_s1 && func_q == segx_pkg::FUNC_ADD),
		.waddr(seg_held_q[segx_pkg::SIW-1:0]),
		.wdata({p_q, pt_rdata}),
		.re   (rd_en && func_q == segx_pkg::FUNC_QRY),
		.raddr(idx_q[segx_pkg::SIW-1:0]),
		.rdata(seg_rdata)
	);

	assign seg_rd  = segx_pkg::seg_t'(seg_rdata);
	assign skip_s1 = (p_q == seg_rd.a) || (q_q == seg_rd.b);

	segx_orient u_o1 (.clk(clk), .a(seg_rd.a), .b(seg_rd.b), .c(p_q),      .sgn(o1));
	segx_orient u_o2 (.clk(clk), .a(seg_rd.a), .b(seg_rd.b), .c(q_q),      .sgn(o2));
	segx_orient u_o3 (.clk(clk), .a(p_q),      .b(q_q),      .c(seg_rd.a), .sgn(o3));
	segx_orient u_o4 (.clk(clk), .a(p_q),      .b(q_q),      .c(seg_rd.b), .sgn(o4));

	assign hit = v_s4 && !skip_s4
		&& ((o1.pos && o2.neg) || (o1.neg && o2.pos))
		&& ((o3.pos && o4.neg) || (o3.neg && o4.pos));

endmodule

// ===== src/segx_ram.sv =====
module segx_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 16,
	localparam int AW = $clog2(DEPTH)
) (
	input  logic             clk,
	input  logic             we,
	input  logic [AW-1:0]    waddr,
	input  logic [WIDTH-1:0] wdata,
	input  logic             re,
	input  logic [AW-1:0]    raddr,
	output logic [WIDTH-1:0] rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule

// ===== src/segx_orient.sv =====
// sign of (b - a) x (c - a), three register stages
module segx_orient (
	input  logic              clk,
	input  segx_pkg::point_t  a,
	input  segx_pkg::point_t  b,
	input  segx_pkg::point_t  c,
	output segx_pkg::sign_t   sgn
);

	logic signed [segx_pkg::DIFF_W-1:0] bax_s1, bay_s1, cax_s1, cay_s1;
	logic signed [segx_pkg::PROD_W-1:0] p1_s2, p2_s2;
	logic signed [segx_pkg::ORI_W-1:0]  v;
	segx_pkg::sign_t                    sgn_s3;

	always_ff @(posedge clk) begin
		bax_s1 <= segx_pkg::DIFF_W'($signed(b.x)) - segx_pkg::DIFF_W'($signed(a.x));
		bay_s1 <= segx_pkg::DIFF_W'($signed(b.y)) - segx_pkg::DIFF_W'($signed(a.y));
		cax_s1 <= segx_pkg::DIFF_W'($signed(c.x)) - segx_pkg::DIFF_W'($signed(a.x));
		cay_s1 <= segx_pkg::DIFF_W'($signed(c.y)) - segx_pkg::DIFF_W'($signed(a.y));
	end

	always_ff @(posedge clk) begin
		p1_s2 <= bax_s1 * cay_s1;
		p2_s2 <= bay_s1 * cax_s1;
	end

	assign v = segx_pkg::ORI_W'(p1_s2) - segx_pkg::ORI_W'(p2_s2);

	always_ff @(posedge clk) begin
		sgn_s3.neg <= v[segx_pkg::ORI_W-1];
		sgn_s3.pos <= !v[segx_pkg::ORI_W-1] && (v != '0);
	end

	assign sgn = sgn_s3;

endmodule
